### rtl/price_level_order_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Price level order queue assertion macros
// Shared concurrent assertion forms for the price level order queue.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_QUEUE_UNIT_ASSERT_SVH
`define PRICE_LEVEL_ORDER_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define PLQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("price level queue check failed");

// next-cycle implication
`define PLQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("price level queue check failed");

`endif

### rtl/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg
// Shared constants, codes and types of the price level order queue.
// ----------------------------------------------------------------------------
package plq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W        = 32;
   localparam int QTY_W       = 32;
   localparam int DELTA_W     = QTY_W + 1;
   localparam int VOL_W       = 40;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   localparam logic [VOL_W-1:0] VOL_SAT_MAX = {1'b0, {(VOL_W-1){1'b1}}};
   localparam logic [VOL_W-1:0] VOL_SAT_MIN = {1'b1, {(VOL_W-1){1'b0}}};

   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SEARCH,
      S_SHIFT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                      en;
      logic signed [DELTA_W-1:0] delta;
   } vol_cmd_type;

endpackage

### rtl/plq_ram.sv
// ----------------------------------------------------------------------------
// plq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module plq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/plq_vol.sv
// ----------------------------------------------------------------------------
// plq_vol
// Running unfilled volume: one saturating signed adder and its register.
// ----------------------------------------------------------------------------
module plq_vol
   import plq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  vol_cmd_type             vol_cmd,
   output logic signed [VOL_W-1:0] vol_sum
);

   logic signed [VOL_W-1:0] sum_ff;
   logic signed [VOL_W-1:0] sum_in;
   logic        [VOL_W:0]   sum_wide;
   logic                    overflow;

   assign sum_wide = {sum_ff[VOL_W-1], sum_ff}
                   + {{(VOL_W+1-DELTA_W){vol_cmd.delta[DELTA_W-1]}}, vol_cmd.delta};
   assign overflow = sum_wide[VOL_W] != sum_wide[VOL_W-1];

   always_comb begin
      sum_in = sum_ff;
      if (vol_cmd.en) begin
         if (overflow) begin
            sum_in = sum_wide[VOL_W] ? VOL_SAT_MIN : VOL_SAT_MAX;
         end else begin
            sum_in = sum_wide[VOL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign vol_sum = sum_ff;

endmodule

### rtl/plq_ctrl.sv
// ----------------------------------------------------------------------------
// plq_ctrl
// Sequencer of the order queue: add, search with one shared compare,
// compaction through the RAM, and the result register.
// ----------------------------------------------------------------------------
module plq_ctrl
   import plq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic [ID_W-1:0]         req_order_id,
   input  logic [QTY_W-1:0]        req_quantity,
   input  logic [QTY_W-1:0]        req_filled,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [VOL_W-1:0]        rsp_total_volume,
   output logic [COUNT_OUT_W-1:0]  rsp_order_count,
   output logic                    rsp_level_empty,
   output logic [ID_W-1:0]         rsp_front_id,
   output logic [ID_W-1:0]         rsp_back_id,
   output logic                    ram_wr_en,
   output logic [ADDR_W-1:0]       ram_wr_addr,
   output logic [ID_W-1:0]         ram_wr_data,
   output logic [ADDR_W-1:0]       ram_rd_addr,
   input  logic [ID_W-1:0]         ram_rd_data,
   output vol_cmd_type             vol_cmd,
   input  logic signed [VOL_W-1:0] vol_sum
);

   state_type                 state_ff, state_in;
   logic                      kind_ff, kind_in;
   logic [ID_W-1:0]           id_ff, id_in;
   logic signed [DELTA_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic [ID_W-1:0]           prev_ff, prev_in;
   logic [ID_W-1:0]           front_ff, front_in;
   logic [ID_W-1:0]           back_ff, back_in;
   status_type                status_ff, status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [VOL_W-1:0]          rsp_total_ff, rsp_total_in;
   logic [COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic [ID_W-1:0]           rsp_front_ff, rsp_front_in;
   logic [ID_W-1:0]           rsp_back_ff, rsp_back_in;

   logic                      req_accept;
   logic                      rsp_accept;
   logic [CNT_W-1:0]          idx_ext;
   logic                      search_last;
   logic                      shift_last;
   logic                      id_match;
   logic                      queue_full;
   logic                      rem_positive;

   assign req_stall  = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   assign idx_ext      = CNT_W'(idx_ff);
   assign search_last  = (idx_ext + CNT_W'(1)) == count_ff;
   assign shift_last   = (idx_ext + CNT_W'(2)) == count_ff;
   assign id_match     = ram_rd_data == id_ff;
   assign queue_full   = count_ff == CNT_W'(QUEUE_DEPTH);
   assign rem_positive = !rem_ff[DELTA_W-1] && (rem_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (id_ff == '0 || kind_ff == KIND_ADD || count_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (search_last) begin
               state_in = S_FINISH;
            end else if (id_match) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (shift_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in       = kind_ff;
      id_in         = id_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_accept ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = id_ff;
      ram_rd_addr   = '0;
      vol_cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in = req_kind;
               id_in   = req_order_id;
               rem_in  = {1'b0, req_quantity} - {1'b0, req_filled};
            end
         end
         S_CHECK: begin
            if (id_ff == '0) begin
               status_in = STATUS_NULL;
            end else if (kind_ff == KIND_ADD) begin
               if (queue_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = count_ff[ADDR_W-1:0];
                  back_in       = id_ff;
                  if (count_ff == '0) begin
                     front_in = id_ff;
                  end
                  count_in      = count_ff + CNT_W'(1);
                  vol_cmd.en    = 1'b1;
                  vol_cmd.delta = rem_ff;
                  status_in     = STATUS_DONE;
               end
            end else if (count_ff == '0) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               idx_in = '0;
            end
         end
         S_SEARCH: begin
            ram_rd_addr = idx_ff + ADDR_W'(1);
            prev_in     = ram_rd_data;
            if (id_match) begin
               status_in = STATUS_DONE;
               if (search_last) begin
                  back_in       = prev_ff;
                  count_in      = count_ff - CNT_W'(1);
                  vol_cmd.en    = rem_positive;
                  vol_cmd.delta = -rem_ff;
               end
            end else if (search_last) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         S_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            ram_rd_addr = idx_ff + ADDR_W'(2);
            if (idx_ff == '0) begin
               front_in = ram_rd_data;
            end
            if (shift_last) begin
               count_in      = count_ff - CNT_W'(1);
               vol_cmd.en    = rem_positive;
               vol_cmd.delta = -rem_ff;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_total_in  = vol_sum;
            rsp_count_in  = COUNT_OUT_W'(count_ff);
            rsp_empty_in  = count_ff == '0;
            rsp_front_in  = (count_ff == '0) ? '0 : front_ff;
            rsp_back_in   = (count_ff == '0) ? '0 : back_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_total_volume = rsp_total_ff;
   assign rsp_order_count  = rsp_count_ff;
   assign rsp_level_empty  = rsp_empty_ff;
   assign rsp_front_id     = rsp_front_ff;
   assign rsp_back_id      = rsp_back_ff;

endmodule

### rtl/price_level_order_queue_unit.sv
// ----------------------------------------------------------------------------
// price_level_order_queue_unit
// One price level of an order book: FIFO of order identifiers kept in a RAM,
// searched and compacted by a small sequencer, with a saturating volume total.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/stall     kind, order_id, quantity, filled
//   rsp_      out        rsp_valid/stall     status, total_volume, order_count,
//                                            level_empty, front_id, back_id
//
// Add, null and rejected transactions go from idle through the check and
// finish states; finish loads the result register. A remove also makes k RAM
// reads to find the match and s RAM writes to close the gap; k + s equals the
// number queued (up to QUEUE_DEPTH). One transaction is in flight; a new one
// is taken once the result register is empty or being drained. Synchronous
// reset empties the level and zeroes the total; queue RAM contents are not
// cleared.
// ----------------------------------------------------------------------------
`include "price_level_order_queue_unit_assert.svh"

module price_level_order_queue_unit
   import plq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [ID_W-1:0]        req_order_id,
   input  logic [QTY_W-1:0]       req_quantity,
   input  logic [QTY_W-1:0]       req_filled,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [VOL_W-1:0]       rsp_total_volume,
   output logic [COUNT_OUT_W-1:0] rsp_order_count,
   output logic                   rsp_level_empty,
   output logic [ID_W-1:0]        rsp_front_id,
   output logic [ID_W-1:0]        rsp_back_id
);

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ID_W-1:0]         ram_wr_data;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [ID_W-1:0]         ram_rd_data;
   vol_cmd_type             vol_cmd;
   logic signed [VOL_W-1:0] vol_sum;

   plq_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_order_id     (req_order_id),
      .req_quantity     (req_quantity),
      .req_filled       (req_filled),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_total_volume (rsp_total_volume),
      .rsp_order_count  (rsp_order_count),
      .rsp_level_empty  (rsp_level_empty),
      .rsp_front_id     (rsp_front_id),
      .rsp_back_id      (rsp_back_id),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .vol_cmd          (vol_cmd),
      .vol_sum          (vol_sum)
   );

   plq_ram #(
      .WIDTH (ID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   plq_vol u_vol (
      .clock   (clock),
      .reset   (reset),
      .vol_cmd (vol_cmd),
      .vol_sum (vol_sum)
   );

`PLQ_ASSERT_IMP(a_no_update_over_result, clock, reset, ram_wr_en || vol_cmd.en, !rsp_valid)
`PLQ_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
`PLQ_ASSERT_IMP(a_count_in_range, clock, reset, rsp_valid, rsp_order_count <= COUNT_OUT_W'(QUEUE_DEPTH))
`PLQ_ASSERT_IMP(a_empty_ids_zero, clock, reset, rsp_valid && rsp_level_empty, rsp_front_id == '0 && rsp_back_id == '0)

endmodule
